// ----- rtl/core/mie_pkg.sv -----
// Package for the MIPS integer execute unit: operation codes, pipeline record, constants.
`timescale 1ns / 1ps
`default_nettype none
package mie_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned OpWidth  = 6;
  localparam int unsigned DivSteps = XLEN;

  localparam logic [XLEN-1:0] DivZeroVal = 32'h7fff_ffff;
  localparam logic [XLEN-1:0] SignBit    = 32'h8000_0000;
  localparam logic [XLEN-1:0] AllOnes    = 32'hffff_ffff;
  localparam logic [XLEN-1:0] LinkOffset = 32'd8;

  localparam logic [OpWidth-1:0] OpAdd    = 6'd0;
  localparam logic [OpWidth-1:0] OpSub    = 6'd1;
  localparam logic [OpWidth-1:0] OpAnd    = 6'd2;
  localparam logic [OpWidth-1:0] OpOr     = 6'd3;
  localparam logic [OpWidth-1:0] OpXor    = 6'd4;
  localparam logic [OpWidth-1:0] OpNor    = 6'd5;
  localparam logic [OpWidth-1:0] OpSll    = 6'd6;
  localparam logic [OpWidth-1:0] OpSrl    = 6'd7;
  localparam logic [OpWidth-1:0] OpSra    = 6'd8;
  localparam logic [OpWidth-1:0] OpSllv   = 6'd9;
  localparam logic [OpWidth-1:0] OpSrlv   = 6'd10;
  localparam logic [OpWidth-1:0] OpSrav   = 6'd11;
  localparam logic [OpWidth-1:0] OpSlt    = 6'd12;
  localparam logic [OpWidth-1:0] OpSltu   = 6'd13;
  localparam logic [OpWidth-1:0] OpAddi   = 6'd14;
  localparam logic [OpWidth-1:0] OpSlti   = 6'd15;
  localparam logic [OpWidth-1:0] OpSltiu  = 6'd16;
  localparam logic [OpWidth-1:0] OpMult   = 6'd17;
  localparam logic [OpWidth-1:0] OpMultu  = 6'd18;
  localparam logic [OpWidth-1:0] OpDiv    = 6'd19;
  localparam logic [OpWidth-1:0] OpDivu   = 6'd20;
  localparam logic [OpWidth-1:0] OpMfhi   = 6'd21;
  localparam logic [OpWidth-1:0] OpMflo   = 6'd22;
  localparam logic [OpWidth-1:0] OpMthi   = 6'd23;
  localparam logic [OpWidth-1:0] OpMtlo   = 6'd24;
  localparam logic [OpWidth-1:0] OpLui    = 6'd25;
  localparam logic [OpWidth-1:0] OpBeq    = 6'd26;
  localparam logic [OpWidth-1:0] OpBne    = 6'd27;
  localparam logic [OpWidth-1:0] OpBgez   = 6'd28;
  localparam logic [OpWidth-1:0] OpBgtz   = 6'd29;
  localparam logic [OpWidth-1:0] OpBlez   = 6'd30;
  localparam logic [OpWidth-1:0] OpBltz   = 6'd31;
  localparam logic [OpWidth-1:0] OpBgezal = 6'd32;
  localparam logic [OpWidth-1:0] OpBltzal = 6'd33;
  localparam logic [OpWidth-1:0] OpJ      = 6'd34;
  localparam logic [OpWidth-1:0] OpJal    = 6'd35;
  localparam logic [OpWidth-1:0] OpJr     = 6'd36;
  localparam logic [OpWidth-1:0] OpJalr   = 6'd37;
  localparam logic [OpWidth-1:0] OpMemAdr = 6'd38;

  typedef struct packed {
    logic [OpWidth-1:0] op;
    logic [XLEN-1:0]    src_a;
    logic [XLEN-1:0]    src_b;
    logic [4:0]         shamt;
    logic [XLEN-1:0]    pc;
    logic [XLEN-1:0]    hi;
    logic [XLEN-1:0]    lo;
  } req_t;

  typedef struct packed {
    logic [XLEN-1:0] res_lo;
    logic [XLEN-1:0] res_hi;
    logic            taken;
    logic [XLEN-1:0] addr;
    logic            is_div;
    logic            neg_q;
    logic            neg_r;
    logic            div_zero;
    logic            div_ovf;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dvs;
  } pipe_t;

endpackage
`default_nettype wire

// ----- rtl/core/mips_integer_execute_unit.sv -----
// MIPS integer execute unit: ALU, branch, multiply and one-bit-per-stage pipelined divider.
//
// Input channel s_axis: tuser carries the operation code, tdata the operands.
// Output channel m_axis: tdata carries one result per input transfer, in order.
// Every operation takes the same path: an input register, an operate stage
// (ALU, branch test, address add, 33x33 multiply, divider setup), 32 divide
// stages that each retire one quotient bit, and an output register.
// One transfer can be taken every cycle while the output is not stalled, as
// the divide stages are fully pipelined.
// All stages advance together whenever the output register is empty or is
// being read; while the receiver holds tready low with a result waiting, the
// whole pipe holds and s_axis_tready is low. Bubbles carry no result.
// Reset clears all valid bits; no transfer is pending after reset and no
// clearing pass is needed.
// Unknown operation codes give an all-zero result.
`timescale 1ns / 1ps
`default_nettype none
module mips_integer_execute_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // tdata: src_a[31:0], src_b[63:32], shift_amount[68:64], instr_addr[100:69],
  //        hi_now[132:101], lo_now[164:133], zero pad [167:165]
  input  wire logic [167:0] s_axis_tdata,
  // tuser: req_type[5:0]
  input  wire logic [5:0]   s_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: result_low[31:0], result_high[63:32], branch_taken[64],
  //        mem_address[96:65], zero pad [103:97]
  output      logic [103:0] m_axis_tdata
);

  localparam int unsigned N = mie_pkg::DivSteps;

  logic                 en;
  logic                 in_vld_q;
  mie_pkg::req_t        in_q;
  logic [N:0]           vld_q;
  mie_pkg::pipe_t       pipe_q [N+1];
  mie_pkg::pipe_t       pipe_d [N+1];
  logic                 out_vld_q;
  logic [103:0]         out_q;
  logic [103:0]         out_d;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // operate stage
  always_comb begin
    logic [31:0] a, b, sb, link;
    logic        sgn, na, nb;
    logic [65:0] prod;
    mie_pkg::pipe_t p;
    a    = in_q.src_a;
    b    = in_q.src_b;
    sb   = {{16{b[15]}}, b[15:0]};
    link = in_q.pc + mie_pkg::LinkOffset;
    sgn  = (in_q.op == mie_pkg::OpMult) || (in_q.op == mie_pkg::OpDiv);
    prod = $signed({sgn & a[31], a}) * $signed({sgn & b[31], b});
    na   = sgn & a[31];
    nb   = sgn & b[31];
    p          = '0;
    p.dvs      = nb ? (32'd0 - b) : b;
    p.quo      = na ? (32'd0 - a) : a;
    p.neg_q    = na ^ nb;
    p.neg_r    = na;
    p.div_zero = (b == '0);
    p.div_ovf  = sgn && (a == mie_pkg::SignBit) && (b == mie_pkg::AllOnes);
    case (in_q.op)
      mie_pkg::OpAdd:    p.res_lo = a + b;
      mie_pkg::OpSub:    p.res_lo = a - b;
      mie_pkg::OpAnd:    p.res_lo = a & b;
      mie_pkg::OpOr:     p.res_lo = a | b;
      mie_pkg::OpXor:    p.res_lo = a ^ b;
      mie_pkg::OpNor:    p.res_lo = ~(a | b);
      mie_pkg::OpSll:    p.res_lo = b << in_q.shamt;
      mie_pkg::OpSrl:    p.res_lo = b >> in_q.shamt;
      mie_pkg::OpSra:    p.res_lo = $unsigned($signed(b) >>> in_q.shamt);
      mie_pkg::OpSllv:   p.res_lo = b << a[4:0];
      mie_pkg::OpSrlv:   p.res_lo = b >> a[4:0];
      mie_pkg::OpSrav:   p.res_lo = $unsigned($signed(b) >>> a[4:0]);
      mie_pkg::OpSlt:    p.res_lo = {31'd0, $signed(a) < $signed(b)};
      mie_pkg::OpSltu:   p.res_lo = {31'd0, a < b};
      mie_pkg::OpAddi:   p.res_lo = a + sb;
      mie_pkg::OpSlti:   p.res_lo = {31'd0, $signed(a) < $signed(sb)};
      mie_pkg::OpSltiu:  p.res_lo = {31'd0, a < sb};
      mie_pkg::OpMult, mie_pkg::OpMultu: begin
        p.res_lo = prod[31:0];
        p.res_hi = prod[63:32];
      end
      mie_pkg::OpDiv, mie_pkg::OpDivu: p.is_div = 1'b1;
      mie_pkg::OpMfhi:   p.res_lo = in_q.hi;
      mie_pkg::OpMflo:   p.res_lo = in_q.lo;
      mie_pkg::OpMthi:   p.res_hi = a;
      mie_pkg::OpMtlo:   p.res_lo = a;
      mie_pkg::OpLui:    p.res_lo = {b[15:0], 16'd0};
      mie_pkg::OpBeq:    p.taken = (a == b);
      mie_pkg::OpBne:    p.taken = (a != b);
      mie_pkg::OpBgez:   p.taken = !a[31];
      mie_pkg::OpBgtz:   p.taken = $signed(a) > 0;
      mie_pkg::OpBlez:   p.taken = !($signed(a) > 0);
      mie_pkg::OpBltz:   p.taken = a[31];
      mie_pkg::OpBgezal: begin p.taken = !a[31]; p.res_lo = link; end
      mie_pkg::OpBltzal: begin p.taken = a[31];  p.res_lo = link; end
      mie_pkg::OpJ, mie_pkg::OpJr: p.taken = 1'b1;
      mie_pkg::OpJal, mie_pkg::OpJalr: begin p.taken = 1'b1; p.res_lo = link; end
      mie_pkg::OpMemAdr: p.addr = a + sb;
      default: ;
    endcase
    pipe_d[0] = p;
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 1; k <= N; k++) begin : g_div
    always_comb begin
      logic [32:0] rsh;
      logic        ge;
      pipe_d[k] = pipe_q[k-1];
      rsh       = {pipe_q[k-1].rem, pipe_q[k-1].quo[31]};
      ge        = rsh >= {1'b0, pipe_q[k-1].dvs};
      pipe_d[k].rem = ge ? 32'(rsh - {1'b0, pipe_q[k-1].dvs}) : rsh[31:0];
      pipe_d[k].quo = {pipe_q[k-1].quo[30:0], ge};
    end
  end

  always_comb begin
    logic [31:0] lo, hi;
    mie_pkg::pipe_t p;
    p  = pipe_q[N];
    lo = p.res_lo;
    hi = p.res_hi;
    if (p.is_div) begin
      if (p.div_zero) begin
        lo = mie_pkg::DivZeroVal;
        hi = mie_pkg::DivZeroVal;
      end else if (p.div_ovf) begin
        lo = mie_pkg::SignBit;
        hi = '0;
      end else begin
        lo = p.neg_q ? (32'd0 - p.quo) : p.quo;
        hi = p.neg_r ? (32'd0 - p.rem) : p.rem;
      end
    end
    out_d = {7'd0, p.addr, p.taken, hi, lo};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= s_axis_tvalid;
      vld_q     <= {vld_q[N-1:0], in_vld_q};
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= '{op: s_axis_tuser, src_a: s_axis_tdata[31:0],
                src_b: s_axis_tdata[63:32], shamt: s_axis_tdata[68:64],
                pc: s_axis_tdata[100:69], hi: s_axis_tdata[132:101],
                lo: s_axis_tdata[164:133]};
      pipe_q[0] <= pipe_d[0];
      for (int i = 1; i <= N; i++) pipe_q[i] <= pipe_d[i];
      out_q <= out_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow pipe advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[N] && pipe_q[N].is_div && pipe_q[N].div_zero)
      |=> (m_axis_tvalid && m_axis_tdata[31:0] == mie_pkg::DivZeroVal
           && m_axis_tdata[63:32] == mie_pkg::DivZeroVal))
    else $error("divide by zero result wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[N] && !pipe_q[N].is_div)
      |=> (m_axis_tdata[31:0] == $past(pipe_q[N].res_lo)))
    else $error("non-divide result altered at output");

endmodule
`default_nettype wire

// ----- dv/tb_mips_integer_execute_unit.sv -----
// Testbench for the MIPS integer execute unit: random and directed operations, scoreboard check.
`timescale 1ns / 1ps
`default_nettype none
module tb_mips_integer_execute_unit;

  typedef struct packed {
    logic [31:0] mem_addr;
    logic        taken;
    logic [31:0] res_hi;
    logic [31:0] res_lo;
  } exec_res_t;

  typedef struct {
    logic [5:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  sh;
    logic [31:0] pc;
    logic [31:0] hi;
    logic [31:0] lo;
  } exec_req_t;

  function automatic exec_res_t execute_op(exec_req_t r);
    exec_res_t   o;
    logic [31:0] imm;
    logic [31:0] link;
    logic [63:0] prod;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    logic [31:0] rm;
    o = '0;
    imm = {{16{r.b[15]}}, r.b[15:0]};
    link = r.pc + 32'd8;
    case (r.op)
      mie_pkg::OpAdd:    o.res_lo = r.a + r.b;
      mie_pkg::OpSub:    o.res_lo = r.a - r.b;
      mie_pkg::OpAnd:    o.res_lo = r.a & r.b;
      mie_pkg::OpOr:     o.res_lo = r.a | r.b;
      mie_pkg::OpXor:    o.res_lo = r.a ^ r.b;
      mie_pkg::OpNor:    o.res_lo = ~(r.a | r.b);
      mie_pkg::OpSll:    o.res_lo = r.b << r.sh;
      mie_pkg::OpSrl:    o.res_lo = r.b >> r.sh;
      mie_pkg::OpSra:    o.res_lo = $signed(r.b) >>> r.sh;
      mie_pkg::OpSllv:   o.res_lo = r.b << r.a[4:0];
      mie_pkg::OpSrlv:   o.res_lo = r.b >> r.a[4:0];
      mie_pkg::OpSrav:   o.res_lo = $signed(r.b) >>> r.a[4:0];
      mie_pkg::OpSlt:    o.res_lo = {31'd0, $signed(r.a) < $signed(r.b)};
      mie_pkg::OpSltu:   o.res_lo = {31'd0, r.a < r.b};
      mie_pkg::OpAddi:   o.res_lo = r.a + imm;
      mie_pkg::OpSlti:   o.res_lo = {31'd0, $signed(r.a) < $signed(imm)};
      mie_pkg::OpSltiu:  o.res_lo = {31'd0, r.a < imm};
      mie_pkg::OpMult: begin
        prod = $signed({{32{r.a[31]}}, r.a}) * $signed({{32{r.b[31]}}, r.b});
        {o.res_hi, o.res_lo} = prod;
      end
      mie_pkg::OpMultu: begin
        prod = {32'd0, r.a} * {32'd0, r.b};
        {o.res_hi, o.res_lo} = prod;
      end
      mie_pkg::OpDiv: begin
        if (r.b == 0) begin
          o.res_lo = 32'h7fff_ffff;
          o.res_hi = 32'h7fff_ffff;
        end else if (r.a == 32'h8000_0000 && r.b == 32'hffff_ffff) begin
          o.res_lo = 32'h8000_0000;
        end else begin
          ma = r.a[31] ? -r.a : r.a;
          mb = r.b[31] ? -r.b : r.b;
          q = ma / mb;
          rm = ma % mb;
          o.res_lo = (r.a[31] != r.b[31]) ? -q : q;
          o.res_hi = r.a[31] ? -rm : rm;
        end
      end
      mie_pkg::OpDivu: begin
        if (r.b == 0) begin
          o.res_lo = 32'h7fff_ffff;
          o.res_hi = 32'h7fff_ffff;
        end else begin
          o.res_lo = r.a / r.b;
          o.res_hi = r.a % r.b;
        end
      end
      mie_pkg::OpMfhi:   o.res_lo = r.hi;
      mie_pkg::OpMflo:   o.res_lo = r.lo;
      mie_pkg::OpMthi:   o.res_hi = r.a;
      mie_pkg::OpMtlo:   o.res_lo = r.a;
      mie_pkg::OpLui:    o.res_lo = {r.b[15:0], 16'd0};
      mie_pkg::OpBeq:    o.taken = (r.a == r.b);
      mie_pkg::OpBne:    o.taken = (r.a != r.b);
      mie_pkg::OpBgez:   o.taken = ~r.a[31];
      mie_pkg::OpBgtz:   o.taken = $signed(r.a) > 0;
      mie_pkg::OpBlez:   o.taken = $signed(r.a) <= 0;
      mie_pkg::OpBltz:   o.taken = r.a[31];
      mie_pkg::OpBgezal: begin o.taken = ~r.a[31]; o.res_lo = link; end
      mie_pkg::OpBltzal: begin o.taken = r.a[31]; o.res_lo = link; end
      mie_pkg::OpJ, mie_pkg::OpJr: o.taken = 1'b1;
      mie_pkg::OpJal, mie_pkg::OpJalr: begin o.taken = 1'b1; o.res_lo = link; end
      mie_pkg::OpMemAdr: o.mem_addr = r.a + imm;
      default: ;
    endcase
    return o;
  endfunction

  class exec_scoreboard;
    exec_res_t pending[$];
    int        errors;

    function void note_request(exec_req_t r);
      pending.push_back(execute_op(r));
    endfunction

    function void check_result(logic [103:0] d);
      exec_res_t got;
      exec_res_t exp;
      got = d[96:0];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      exp = pending.pop_front();
      if (got.res_lo !== exp.res_lo || got.res_hi !== exp.res_hi ||
          got.taken !== exp.taken || got.mem_addr !== exp.mem_addr || d[103:97] !== 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp lo %h hi %h tk %b adr %h, got lo %h hi %h tk %b adr %h",
                   exp.res_lo, exp.res_hi, exp.taken, exp.mem_addr,
                   got.res_lo, got.res_hi, got.taken, got.mem_addr);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [5:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  exec_scoreboard sb = new();
  int             idle_cycles = 0;
  localparam int  IdleLimit = 2000;

  mips_integer_execute_unit uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // result side: random stall before each transfer
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_req(exec_req_t r, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.op;
    s_axis_tdata <= {3'b0, r.lo, r.hi, r.pc, r.sh, r.b, r.a};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic exec_req_t rand_req();
    exec_req_t r;
    r.op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(39, 63)) : 6'($urandom_range(0, 38));
    r.a = pick_word();
    r.b = pick_word();
    if ($urandom_range(0, 9) == 0) r.b = r.a;
    r.sh = 5'($urandom);
    r.pc = $urandom;
    r.hi = $urandom;
    r.lo = $urandom;
    return r;
  endfunction

  initial begin
    exec_req_t r;
    int burst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: every opcode with extreme operands, then the divide and multiply corners and an unknown opcode
    for (int i = 0; i <= 38; i++) begin
      r = '{6'(i), 32'h8000_0000, 32'hffff_ffff, 5'd31, 32'hffff_fffc,
            32'hffff_ffff, 32'h0};
      r.lo = 32'h0;
      send_req(r, 0);
    end
    send_req('{mie_pkg::OpDiv, 32'h8000_0000, 32'hffff_ffff, 5'd0, 0, 0, 0}, 0);
    send_req('{mie_pkg::OpDiv, 32'hffff_fff9, 32'h0, 5'd0, 0, 0, 0}, 0);
    send_req('{mie_pkg::OpDivu, 32'h1234, 32'h0, 5'd0, 0, 0, 0}, 0);
    send_req('{mie_pkg::OpDiv, 32'hffff_fff9, 32'd2, 5'd0, 0, 0, 0}, 0);
    send_req('{mie_pkg::OpMult, 32'h8000_0000, 32'h8000_0000, 5'd0, 0, 0, 0}, 0);
    send_req('{mie_pkg::OpMultu, 32'hffff_ffff, 32'hffff_ffff, 5'd0, 0, 0, 0}, 0);
    send_req('{6'd63, 32'hffff_ffff, 32'hffff_ffff, 5'd31, 32'hffff_ffff,
               32'hffff_ffff, 32'hffff_ffff}, 0);
    // let the pipe drain once before random traffic
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 1400; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        r = rand_req();
        send_req(r, (burst > 20) ? 0 : $urandom_range(0, 15));
      end
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
